// File: rtl/priority_sorted_task_table_core_assert.svh
// assertion macros shared by the task table rtl
// expects clk and rst (synchronous, active high) in the enclosing module
`ifndef PRIORITY_SORTED_TASK_TABLE_CORE_ASSERT_SVH
`define PRIORITY_SORTED_TASK_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSTT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PSTT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pstt_pkg.sv
// shared types and constants for the priority sorted task table
// micro-op encodings, control word, datapath flags, beat layouts; no dependencies
package pstt_pkg;

  // field widths of one input and one result beat
  localparam int FUNC_W   = 2;
  localparam int PRIO_W   = 8;
  localparam int IDW      = 16;
  localparam int STATUS_W = 2;

  // input tdata layout, lowest bit first
  localparam int FUNC_LSB   = 0;
  localparam int PRIO_LSB   = FUNC_LSB + FUNC_W;
  localparam int ID_LSB     = PRIO_LSB + PRIO_W;
  localparam int MINP_LSB   = ID_LSB + IDW;
  localparam int IN_USED_W  = MINP_LSB + PRIO_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int OUT_USED_W  = STATUS_W + PRIO_W + IDW;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // results reported by one list request
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LIST   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // microprogram step addresses
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS0,
    S_INS1,
    S_INS2,
    S_REM0,
    S_REM1,
    S_REM2,
    S_REM3,
    S_REM4,
    S_LST0,
    S_LST1,
    S_LST2,
    S_RES_OK,
    S_RES_FULL,
    S_RES_MISS
  } step_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_FULL,
    C_INS_STOP,
    C_SCAN_DONE,
    C_IDX_END,
    C_SHIFT_END,
    C_LIST_END
  } cond_t;

  typedef enum logic [2:0] {
    IDX_KEEP,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_PLUS,
    OFF_MINUS
  } rd_off_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_STATUS,
    EM_PEND,
    EM_FINAL
  } emit_t;

  // one word of the control store
  typedef struct packed {
    cond_t   cond;
    step_t   tgt;
    step_t   nxt;
    logic    dispatch;
    logic    in_ready;
    logic    load;
    idx_op_t idx_op;
    rd_off_t rd_off;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    emit_t   emit;
    status_t status;
    logic    capture;
  } uword_t;

  // actions handed to the datapath after branch and stall gating
  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    rd_off_t rd_off;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    emit_t   emit;
    status_t status;
    logic    capture;
  } ctl_t;

  // datapath tests seen by the sequencer
  typedef struct packed {
    logic full;
    logic ins_stop;
    logic scan_done;
    logic idx_end;
    logic shift_end;
    logic list_end;
    logic list_hit;
    logic pend_hold;
    logic out_free;
  } flags_t;

endpackage

// File: rtl/priority_sorted_task_table_core.sv
// top level of the priority sorted task table
// ties the microcoded sequencer to the datapath; uses pstt_pkg, pstt_seq, pstt_dp

// Task table kept in descending priority order, equal priorities in arrival
// order, one request at a time. s_tready is high only while the block waits
// for a request; every request yields at least one result beat, and the last
// beat of a request has m_tlast set. The entries live in one simple dual-port
// ram and a microprogram walks them one entry per cycle through its single
// read port, except while a step that emits a result waits for the result
// channel to take the beat it still holds. A request is taken in the idle
// step, which the microprogram returns to after each operation.
// No clearing pass after reset.
module priority_sorted_task_table_core #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // func, priority_req, task_id, min_prio, zero pad
  input  logic [pstt_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status, out_priority, out_id, zero pad
  output logic [pstt_pkg::OUT_TDATA_W-1:0] m_tdata,
  // entry_valid
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import pstt_pkg::*;

  ctl_t   ctl;
  flags_t flags;
  func_t  in_func;

  assign in_func = func_t'(s_tdata[FUNC_LSB +: FUNC_W]);

  // control
  pstt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (in_func),
    .flags    (flags),
    .in_ready (s_tready),
    .ctl      (ctl)
  );

  // storage and result path
  pstt_dp #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_data (s_tdata),
    .ctl     (ctl),
    .m_ready (m_tready),
    .flags   (flags),
    .m_valid (m_tvalid),
    .m_data  (m_tdata),
    .m_user  (m_tuser),
    .m_last  (m_tlast)
  );

endmodule

// File: rtl/pstt_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module pstt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pstt_dp.sv
// task table datapath: entry ram, walk index, entry count, list pending slot
// and the result register; uses pstt_pkg, pstt_ram and the assertion header
`include "priority_sorted_task_table_core_assert.svh"

module pstt_dp #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pstt_pkg::IN_TDATA_W-1:0]  in_data,
  input  pstt_pkg::ctl_t                   ctl,
  input  logic                             m_ready,
  output pstt_pkg::flags_t                 flags,
  output logic                             m_valid,
  output logic [pstt_pkg::OUT_TDATA_W-1:0] m_data,
  output logic                             m_user,
  output logic                             m_last
);
  import pstt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = PRIO_W + ID_BITS;

  logic [PRIO_W-1:0]      prio_r;
  logic [ID_BITS-1:0]     key_r;
  logic [PRIO_W-1:0]      minp_r;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          idx_next;
  logic [CW-1:0]          count;
  logic [RES_W-1:0]       n;
  logic                   hold;
  logic [PRIO_W-1:0]      pend_prio;
  logic [ID_BITS-1:0]     pend_key;
  logic [IDW-1:0]         pend_id;
  logic [ID_BITS+IDW-1:0] key_wide;
  logic [ID_BITS+IDW-1:0] id_wide;
  logic [ID_BITS-1:0]     key_in;
  logic [CW:0]            ra_wide;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [EW-1:0]          wdata;
  logic [EW-1:0]          rdata;
  logic [PRIO_W-1:0]      rd_prio;
  logic [ID_BITS-1:0]     rd_key;
  status_t                out_status;
  logic                   out_ev;
  logic [PRIO_W-1:0]      out_prio;
  logic [IDW-1:0]         out_id;
  logic                   out_last;

  // key taken to the stored width, low bits kept
  assign key_wide = {{ID_BITS{1'b0}}, in_data[ID_LSB +: IDW]};
  assign key_in   = key_wide[ID_BITS-1:0];

  // low result bits of the pending key
  assign id_wide = {{IDW{1'b0}}, pend_key};
  assign pend_id = id_wide[IDW-1:0];

  assign rd_prio = rdata[EW-1 -: PRIO_W];
  assign rd_key  = rdata[ID_BITS-1:0];

  // request fields, held for the whole operation
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prio_r <= in_data[PRIO_LSB +: PRIO_W];
      key_r  <= key_in;
      minp_r <= in_data[MINP_LSB +: PRIO_W];
    end
  end

  // walk index
  always_comb begin
    unique case (ctl.idx_op)
      IDX_KEEP:  idx_next = idx;
      IDX_ZERO:  idx_next = '0;
      IDX_COUNT: idx_next = count;
      IDX_INC:   idx_next = idx + CW'(1);
      IDX_DEC:   idx_next = idx - CW'(1);
      default:   idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  // read address follows the next index so data lines up with the next step
  always_comb begin
    unique case (ctl.rd_off)
      OFF_ZERO:  ra_wide = {1'b0, idx_next};
      OFF_PLUS:  ra_wide = {1'b0, idx_next} + (CW+1)'(1);
      OFF_MINUS: ra_wide = {1'b0, idx_next} - (CW+1)'(1);
      default:   ra_wide = {1'b0, idx_next};
    endcase
  end
  assign raddr = ra_wide[AW-1:0];

  // write port: moved neighbour or the new pair
  assign we    = (ctl.wr_op != WR_NONE);
  assign wdata = (ctl.wr_op == WR_NEW) ? {prio_r, key_r} : rdata;

  pstt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (we),
    .waddr (idx[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries in use
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctl.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // list pending slot and match count
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
      n    <= '0;
    end else if (ctl.load) begin
      hold <= 1'b0;
      n    <= '0;
    end else if (ctl.capture) begin
      hold <= 1'b1;
      n    <= n + RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      pend_prio <= rd_prio;
      pend_key  <= rd_key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (ctl.emit != EM_NONE) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.emit)
      EM_STATUS: begin
        out_status <= ctl.status;
        out_ev     <= 1'b0;
        out_prio   <= '0;
        out_id     <= '0;
        out_last   <= 1'b1;
      end
      EM_PEND: begin
        out_status <= ST_OK;
        out_ev     <= 1'b1;
        out_prio   <= pend_prio;
        out_id     <= pend_id;
        out_last   <= 1'b0;
      end
      EM_FINAL: begin
        out_status <= ST_OK;
        out_ev     <= hold;
        out_prio   <= hold ? pend_prio : '0;
        out_id     <= hold ? pend_id : '0;
        out_last   <= 1'b1;
      end
      default: begin
        out_status <= out_status;
      end
    endcase
  end

  assign m_data = {{OUT_PAD_W{1'b0}}, out_id, out_prio, out_status};
  assign m_user = out_ev;
  assign m_last = out_last;

  // tests for the sequencer
  always_comb begin
    flags.full      = (count == CW'(CAPACITY));
    flags.idx_end   = (idx == count);
    flags.ins_stop  = (idx == '0) || (rd_prio >= prio_r);
    flags.scan_done = (idx == count) || (rd_key == key_r);
    flags.shift_end = (({1'b0, idx} + (CW+1)'(1)) >= {1'b0, count});
    flags.list_end  = (idx == count) || (n == RES_W'(MAX_RESULTS));
    flags.list_hit  = (rd_prio >= minp_r);
    flags.pend_hold = hold;
    flags.out_free  = !m_valid || m_ready;
  end

  `PSTT_CHECK(a_emit_when_free, ctl.emit != EM_NONE, !m_valid || m_ready, "result over a held beat")
  `PSTT_CHECK(a_write_in_table, we, (idx < CAPACITY) && (idx <= count), "entry write out of table")
  `PSTT_CHECK(a_grow_not_full, ctl.cnt_op == CNT_INC, count < CAPACITY, "insert into full table")
  `PSTT_CHECK(a_shrink_not_empty, ctl.cnt_op == CNT_DEC, count != '0, "remove from empty table")

endmodule

// File: rtl/pstt_seq.sv
// microcoded sequencer: control store, step counter, branch and stall logic
// uses pstt_pkg and the assertion header
`include "priority_sorted_task_table_core_assert.svh"

module pstt_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pstt_pkg::func_t  in_func,
  input  pstt_pkg::flags_t flags,
  output logic             in_ready,
  output pstt_pkg::ctl_t   ctl
);
  import pstt_pkg::*;

  step_t  upc;
  step_t  upc_next;
  uword_t uw;
  logic   cond_hit;
  logic   emit_want;
  logic   stall;
  logic   act;

  // control store
  function automatic uword_t urom(step_t s);
    uword_t w;
    w.cond     = C_NEVER;
    w.tgt      = S_IDLE;
    w.nxt      = S_IDLE;
    w.dispatch = 1'b0;
    w.in_ready = 1'b0;
    w.load     = 1'b0;
    w.idx_op   = IDX_KEEP;
    w.rd_off   = OFF_ZERO;
    w.wr_op    = WR_NONE;
    w.cnt_op   = CNT_KEEP;
    w.emit     = EM_NONE;
    w.status   = ST_OK;
    w.capture  = 1'b0;
    unique case (s)
      S_IDLE: begin
        w.cond     = C_NO_IN;
        w.tgt      = S_IDLE;
        w.dispatch = 1'b1;
        w.in_ready = 1'b1;
        w.load     = 1'b1;
      end
      // insert: walk down from the tail moving lower priorities up a slot
      S_INS0: begin
        w.cond   = C_FULL;
        w.tgt    = S_RES_FULL;
        w.idx_op = IDX_COUNT;
        w.rd_off = OFF_MINUS;
        w.nxt    = S_INS1;
      end
      S_INS1: begin
        w.cond   = C_INS_STOP;
        w.tgt    = S_INS2;
        w.wr_op  = WR_SHIFT;
        w.idx_op = IDX_DEC;
        w.rd_off = OFF_MINUS;
        w.nxt    = S_INS1;
      end
      S_INS2: begin
        w.wr_op  = WR_NEW;
        w.cnt_op = CNT_INC;
        w.nxt    = S_RES_OK;
      end
      // remove: find the first key match, then close the gap
      S_REM0: begin
        w.idx_op = IDX_ZERO;
        w.nxt    = S_REM1;
      end
      S_REM1: begin
        w.cond   = C_SCAN_DONE;
        w.tgt    = S_REM2;
        w.idx_op = IDX_INC;
        w.nxt    = S_REM1;
      end
      S_REM2: begin
        w.cond   = C_IDX_END;
        w.tgt    = S_RES_MISS;
        w.rd_off = OFF_PLUS;
        w.nxt    = S_REM3;
      end
      S_REM3: begin
        w.cond   = C_SHIFT_END;
        w.tgt    = S_REM4;
        w.wr_op  = WR_SHIFT;
        w.idx_op = IDX_INC;
        w.rd_off = OFF_PLUS;
        w.nxt    = S_REM3;
      end
      S_REM4: begin
        w.cnt_op = CNT_DEC;
        w.nxt    = S_RES_OK;
      end
      // list: one match held back so the final beat can carry last
      S_LST0: begin
        w.idx_op = IDX_ZERO;
        w.nxt    = S_LST1;
      end
      S_LST1: begin
        w.cond    = C_LIST_END;
        w.tgt     = S_LST2;
        w.emit    = EM_PEND;
        w.capture = 1'b1;
        w.idx_op  = IDX_INC;
        w.nxt     = S_LST1;
      end
      S_LST2: begin
        w.emit = EM_FINAL;
        w.nxt  = S_IDLE;
      end
      S_RES_OK: begin
        w.emit   = EM_STATUS;
        w.status = ST_OK;
        w.nxt    = S_IDLE;
      end
      S_RES_FULL: begin
        w.emit   = EM_STATUS;
        w.status = ST_FULL;
        w.nxt    = S_IDLE;
      end
      S_RES_MISS: begin
        w.emit   = EM_STATUS;
        w.status = ST_MISSING;
        w.nxt    = S_IDLE;
      end
      default: begin
        w.nxt = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // entry step of each operation
  function automatic step_t dispatch_to(func_t f);
    step_t d;
    unique case (f)
      FN_INSERT: d = S_INS0;
      FN_REMOVE: d = S_REM0;
      FN_LIST:   d = S_LST0;
      FN_NOP:    d = S_RES_OK;
      default:   d = S_RES_OK;
    endcase
    return d;
  endfunction

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // branch select, stall and action gating
  always_comb begin
    uw = urom(upc);

    unique case (uw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_NO_IN:     cond_hit = !in_valid;
      C_FULL:      cond_hit = flags.full;
      C_INS_STOP:  cond_hit = flags.ins_stop;
      C_SCAN_DONE: cond_hit = flags.scan_done;
      C_IDX_END:   cond_hit = flags.idx_end;
      C_SHIFT_END: cond_hit = flags.shift_end;
      C_LIST_END:  cond_hit = flags.list_end;
      default:     cond_hit = 1'b0;
    endcase

    unique case (uw.emit) inside
      EM_STATUS, EM_FINAL: emit_want = 1'b1;
      EM_PEND:             emit_want = flags.list_hit && flags.pend_hold;
      default:             emit_want = 1'b0;
    endcase

    stall = emit_want && !flags.out_free;
    act   = !cond_hit && !stall;

    if (cond_hit) begin
      upc_next = uw.tgt;
    end else if (stall) begin
      upc_next = upc;
    end else if (uw.dispatch) begin
      upc_next = dispatch_to(in_func);
    end else begin
      upc_next = uw.nxt;
    end

    in_ready    = uw.in_ready;
    ctl.load    = act && uw.load;
    ctl.idx_op  = act ? uw.idx_op : IDX_KEEP;
    ctl.rd_off  = uw.rd_off;
    ctl.wr_op   = act ? uw.wr_op : WR_NONE;
    ctl.cnt_op  = act ? uw.cnt_op : CNT_KEEP;
    ctl.emit    = (act && emit_want) ? uw.emit : EM_NONE;
    ctl.status  = uw.status;
    ctl.capture = act && uw.capture && flags.list_hit;
  end

  `PSTT_CHECK_NEXT(a_accept_starts_op, in_valid && in_ready, upc != S_IDLE, "request taken but no op run")

endmodule

// File: tb/tb_priority_sorted_task_table_core.sv
// self-checking testbench for the priority sorted task table core
// drives request beats, predicts every result beat and checks them in order; needs pstt_pkg
module tb_priority_sorted_task_table_core;
  import pstt_pkg::*;

  localparam int CAP       = 16;
  localparam int CYCLE_CAP = 500000;
  localparam int HOLD_LEN  = 300;
  localparam int DRAIN_LEN = 40;
  localparam int PHASE_LEN = 75;

  // one result beat as seen on the master side
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    status_t              status;
    logic                 listed;
    logic [PRIO_W-1:0]    prio;
    logic [IDW-1:0]       key;
    logic                 last;
  } beat_t;

  // ordered task table and the result beats it still owes
  class task_table_tracker;
    logic [PRIO_W-1:0] prios[CAP];
    logic [IDW-1:0]    keys[CAP];
    int                count;
    beat_t             pending[$];
    int                errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void push_beat(status_t st, logic listed, logic [PRIO_W-1:0] p,
                            logic [IDW-1:0] k, logic last);
      beat_t b;
      b.pad    = '0;
      b.status = st;
      b.listed = listed;
      b.prio   = p;
      b.key    = k;
      b.last   = last;
      pending.push_back(b);
    endfunction

    // update the table for one accepted request and queue its beats
    function void accept_request(func_t f, logic [PRIO_W-1:0] p, logic [IDW-1:0] k,
                                 logic [PRIO_W-1:0] minp);
      int pos;
      int hits;
      int n;
      case (f)
        FN_INSERT: begin
          if (count >= CAP) begin
            push_beat(ST_FULL, 1'b0, '0, '0, 1'b1);
          end else begin
            // new entry goes after every entry of equal or higher priority
            pos = 0;
            while (pos < count && prios[pos] >= p) pos++;
            for (int i = count; i > pos; i--) begin
              prios[i] = prios[i-1];
              keys[i]  = keys[i-1];
            end
            prios[pos] = p;
            keys[pos]  = k;
            count++;
            push_beat(ST_OK, 1'b0, '0, '0, 1'b1);
          end
        end
        FN_REMOVE: begin
          pos = 0;
          while (pos < count && keys[pos] != k) pos++;
          if (pos == count) begin
            push_beat(ST_MISSING, 1'b0, '0, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < count; i++) begin
              prios[i] = prios[i+1];
              keys[i]  = keys[i+1];
            end
            count--;
            push_beat(ST_OK, 1'b0, '0, '0, 1'b1);
          end
        end
        FN_LIST: begin
          // count matches first so the final one can carry last
          hits = 0;
          for (int i = 0; i < count; i++)
            if (prios[i] >= minp && hits < MAX_RESULTS) hits++;
          if (hits == 0) begin
            push_beat(ST_OK, 1'b0, '0, '0, 1'b1);
          end else begin
            n = 0;
            for (int i = 0; i < count && n < hits; i++) begin
              if (prios[i] >= minp) begin
                n++;
                push_beat(ST_OK, 1'b1, prios[i], keys[i], n == hits);
              end
            end
          end
        end
        default: begin
          push_beat(ST_OK, 1'b0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    // compare one accepted result beat with the oldest one owed
    function void check_beat(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  task_table_tracker tracker;
  int  send_idle;
  int  recv_idle = 77;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  priority_sorted_task_table_core #(
    .CAPACITY(CAP),
    .ID_BITS (IDW)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, well above the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic beat_t capture_beat();
    beat_t b;
    b.pad    = m_tdata[OUT_TDATA_W-1:OUT_USED_W];
    b.status = status_t'(m_tdata[STATUS_W-1:0]);
    b.listed = m_tuser;
    b.prio   = m_tdata[STATUS_W +: PRIO_W];
    b.key    = m_tdata[STATUS_W+PRIO_W +: IDW];
    b.last   = m_tlast;
    return b;
  endfunction

  // result side: check each beat, then decide ready for the next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_beat(capture_beat());
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // long hold-off so the table backs up into the request side
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // offer one request beat and wait for it to be taken
  task automatic send_request(input func_t f, input logic [PRIO_W-1:0] p,
                              input logic [IDW-1:0] k, input logic [PRIO_W-1:0] minp);
    logic [IN_TDATA_W-1:0] word;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = '0;
    word[FUNC_LSB +: FUNC_W] = f;
    word[PRIO_LSB +: PRIO_W] = p;
    word[ID_LSB +: IDW]      = k;
    word[MINP_LSB +: PRIO_W] = minp;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    tracker.accept_request(f, p, k, minp);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'hFF : 8'h00;
      3:       return 8'(64 * $urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [IDW-1:0] pick_key();
    return $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom_range(65535));
  endfunction

  // mostly well-formed traffic steered by the current table fill
  task automatic send_random_request();
    int r;
    int ins_pct;
    logic [IDW-1:0] k;
    logic [PRIO_W-1:0] minp;
    r = $urandom_range(99);
    ins_pct = (tracker.count < 6) ? 55 : (tracker.count >= 13) ? 25 : 40;
    if (r < ins_pct) begin
      send_request(FN_INSERT, pick_prio(), pick_key(), 8'($urandom_range(255)));
    end else if (r < ins_pct + 28) begin
      if (tracker.count > 0 && $urandom_range(99) < 75)
        k = tracker.keys[$urandom_range(tracker.count - 1)];
      else
        k = pick_key();
      send_request(FN_REMOVE, 8'($urandom_range(255)), k, 8'($urandom_range(255)));
    end else if (r < 94) begin
      case ($urandom_range(3))
        0: minp = 8'h00;
        1: minp = (tracker.count > 0) ? tracker.prios[$urandom_range(tracker.count - 1)]
                                      : 8'hFF;
        default: minp = 8'($urandom_range(255));
      endcase
      send_request(FN_LIST, 8'($urandom_range(255)), 16'($urandom_range(65535)), minp);
    end else begin
      send_request(FN_NOP, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                   8'($urandom_range(255)));
    end
  endtask

  // directed opening: empty table, fill, overflow, lists, removals
  task automatic run_directed();
    logic [PRIO_W-1:0] fill_prio[CAP] = '{100, 255, 0, 100, 255, 100, 50, 0,
                                          200, 100, 128, 7, 255, 1, 254, 100};
    logic [IDW-1:0]    fill_key[CAP]  = '{16'h0001, 16'hFFFF, 16'h0000, 16'h0002,
                                          16'h0003, 16'h0004, 16'h0005, 16'h0006,
                                          16'h0007, 16'h0001, 16'h0008, 16'h0009,
                                          16'h000A, 16'h000B, 16'h000C, 16'h000D};
    send_request(FN_REMOVE, 8'h00, 16'h0005, 8'h00);
    send_request(FN_LIST, 8'hFF, 16'hFFFF, 8'h00);
    send_request(FN_NOP, 8'hFF, 16'hFFFF, 8'hFF);
    for (int i = 0; i < CAP; i++)
      send_request(FN_INSERT, fill_prio[i], fill_key[i], 8'($urandom_range(255)));
    // table is full now
    send_request(FN_INSERT, 8'd90, 16'h000E, 8'h00);
    send_request(FN_LIST, 8'h00, 16'h0000, 8'h00);
    send_request(FN_LIST, 8'h00, 16'h0000, 8'hFF);
    // duplicate key: only the first in table order goes
    send_request(FN_REMOVE, 8'hFF, 16'h0001, 8'hFF);
    send_request(FN_REMOVE, 8'h00, 16'hABCD, 8'h00);
    send_request(FN_LIST, 8'hFF, 16'hFFFF, 8'd101);
  endtask

  // stimulus, drain and verdict
  initial begin
    tracker = new();
    send_idle = 7;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 7;
          recv_idle <= 77;
        end
        1: begin
          send_idle = 77;
          recv_idle <= 7;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
          hold_req  <= 1'b1;
        end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) send_random_request();
    end
    s_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
    if (tracker.pending.size() != 0)
      $display("%0t: %0d result beats never arrived", $time, tracker.pending.size());
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: priority_sorted_task_table_core.f
+incdir+rtl
rtl/pstt_pkg.sv
rtl/pstt_ram.sv
rtl/pstt_dp.sv
rtl/pstt_seq.sv
rtl/priority_sorted_task_table_core.sv
tb/tb_priority_sorted_task_table_core.sv
